// ===== hdl/pr80_pkg.sv =====
// pr80_pkg: shared constants and round functions for the present-80 encrypt pipeline
// depends on nothing; used by present80_block_encrypt_unit
`default_nettype none

package pr80_pkg;

  localparam int KEY_W   = 80;
  localparam int BLK_W   = 64;
  localparam int KUP_W   = 16;
  localparam int CNT_W   = 5;
  localparam int IN_W    = KUP_W + BLK_W + BLK_W;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [3:0] SBOX [16] = '{
    4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
    4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  function automatic blk_t sub_layer(input blk_t x);
    blk_t y;
    y = '0;
    for (int n = 0; n < BLK_W / 4; n++) begin
      y[4*n +: 4] = SBOX[x[4*n +: 4]];
    end
    return y;
  endfunction

  // bit i moves to 16*i mod 63, bit 63 stays
  function automatic blk_t perm_layer(input blk_t x);
    blk_t y;
    y = '0;
    for (int b = 0; b < BLK_W; b++) begin
      y[(b / 4) + (b % 4) * 16] = x[b];
    end
    return y;
  endfunction

  function automatic blk_t round_fn(input blk_t st, input key_t key);
    return perm_layer(sub_layer(st ^ key[KEY_W-1 -: BLK_W]));
  endfunction

  // rotate left by 61, s-box on top nibble, counter into bits 19..15
  function automatic key_t key_update(input key_t key, input cnt_t cnt);
    key_t k;
    k = {key[18:0], key[KEY_W-1:19]};
    k[KEY_W-1 -: 4] = SBOX[k[KEY_W-1 -: 4]];
    k[19:15] = k[19:15] ^ cnt;
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/present80_block_encrypt_unit.sv =====
// present80_block_encrypt_unit: present-80 block encryption, one round per pipeline stage
// depends on pr80_pkg (round and key schedule functions)
//
// usage:
//   input channel in_*: each item carries an 80-bit key and one 64-bit plaintext block
//   result channel out_*: one 64-bit ciphertext item per input item, in order
//   stage 0 registers the item, stages 1..NUM_ROUND_KEYS-1 each run one round and one
//   key schedule step, and an output register adds the last round key
//   throughput: one item per cycle when out_tready is high, set by one round of logic between stage registers
//   each stage moves forward when the stage after it is empty or moving, so empty
//   stages fill while the output stalls; in_tready drops only when every stage holds
//   an item and the result waits on out_tready
//   reset: rst_n low clears all stage valid bits; no item is in flight afterwards
`default_nettype none

module present80_block_encrypt_unit #(
  parameter int NUM_ROUND_KEYS = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // [15:0] key_upper, [79:16] key_lower, [143:80] plaintext
  input  wire [pr80_pkg::IN_W-1:0] in_tdata,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // [63:0] ciphertext
  output logic [pr80_pkg::BLK_W-1:0] out_tdata
);

  import pr80_pkg::*;

  localparam int NS = NUM_ROUND_KEYS;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] stg_rdy;
  blk_t          st_r  [NS];
  key_t          key_r [NS];
  logic          out_vld_r;
  blk_t          out_dat_r;
  logic          out_rdy;

  assign out_rdy = !out_vld_r || out_tready;

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      logic nxt_rdy;
      logic prv_vld;
      blk_t st_nxt;
      key_t key_nxt;

      if (k == NS - 1) begin : g_last
        assign nxt_rdy = out_rdy;
      end else begin : g_mid
        assign nxt_rdy = stg_rdy[k+1];
      end

      if (k == 0) begin : g_first
        assign prv_vld = in_tvalid;
        assign st_nxt  = in_tdata[KUP_W+BLK_W +: BLK_W];
        assign key_nxt = {in_tdata[0 +: KUP_W], in_tdata[KUP_W +: BLK_W]};
      end else begin : g_round
        assign prv_vld = vld_r[k-1];
        assign st_nxt  = round_fn(st_r[k-1], key_r[k-1]);
        assign key_nxt = key_update(key_r[k-1], CNT_W'(k));
      end

      assign stg_rdy[k] = !vld_r[k] || nxt_rdy;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (stg_rdy[k]) begin
          vld_r[k] <= prv_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (stg_rdy[k] && prv_vld) begin
          st_r[k]  <= st_nxt;
          key_r[k] <= key_nxt;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy) begin
      out_vld_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && vld_r[NS-1]) begin
      out_dat_r <= st_r[NS-1] ^ key_r[NS-1][KEY_W-1 -: BLK_W];
    end
  end

  assign in_tready  = stg_rdy[0];
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

  // accepted item lands in the first stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted item missing from first stage");

  // back pressure at the input only when the whole pipe is full
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> ((&vld_r) && out_tvalid && !out_tready))
    else $error("input stalled with room in pipeline");

  // a held result keeps an occupied last stage occupied
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NS-1] && out_tvalid && !out_tready) |=> vld_r[NS-1])
    else $error("last stage item lost during stall");

  // reset empties the output
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
